[rtl/hlcm_pkg.sv]
// Package for the hyperperiod accumulator: field widths, command codes and
// back-end state encoding. No dependencies.
`default_nettype none

package hlcm_pkg;

    localparam int PERIOD_BITS_DEF = 32;
    localparam int PERIOD_W        = 32;
    localparam int HP_W            = 64;
    localparam int HALF_W          = HP_W / 2;
    localparam int CNT_W           = $clog2(HP_W + 1);
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        OP_START,
        OP_COMBINE,
        OP_HOLD
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_GCD,
        S_DIV,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_WRITE
    } t_state;

endpackage

`default_nettype wire

[rtl/hlcm_if.sv]
// Stream interfaces for task periods in and hyperperiod results out.
// Depends on nothing; widths follow the fixed field widths.
`default_nettype none

interface hlcm_task_if;
    logic        valid;
    logic        ready;
    logic [31:0] period;
    logic        first;

    modport source (output valid, output period, output first, input ready);
    modport sink   (input valid, input period, input first, output ready);
endinterface

interface hlcm_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] hyperperiod;
    logic        overflow;

    modport source (output valid, output hyperperiod, output overflow, input ready);
    modport sink   (input valid, input hyperperiod, input overflow, output ready);
endinterface

`default_nettype wire

[rtl/hlcm_front.sv]
// Front end: accepts task beats, masks the period and classifies each beat
// into a command held in a two-entry queue. Uses hlcm_pkg and hlcm_task_if.
`default_nettype none

module hlcm_front #(
    parameter int PB = hlcm_pkg::PERIOD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hlcm_task_if.sink        i_task,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output hlcm_pkg::t_op    o_cmd_op,
    output logic [PB-1:0]    o_cmd_period
);
    import hlcm_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(QUEUE_DEPTH);

    t_op             r_op  [QUEUE_DEPTH];
    logic [PB-1:0]   r_per [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;

    logic            w_push;
    logic            w_pop;
    logic [PB-1:0]   w_period;
    t_op             w_op;

    assign w_period     = i_task.period[PB-1:0];
    assign i_task.ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign w_push       = i_task.valid && i_task.ready;
    assign o_cmd_valid  = (r_cnt != '0);
    assign w_pop        = o_cmd_valid && i_cmd_ready;
    assign o_cmd_op     = r_op[r_rd];
    assign o_cmd_period = r_per[r_rd];

    always_comb begin
        priority if (i_task.first) begin
            w_op = OP_START;
        end else if (w_period == '0) begin
            w_op = OP_HOLD;
        end else begin
            w_op = OP_COMBINE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= AW'((32'(r_wr) + 1) % QUEUE_DEPTH);
            end
            if (w_pop) begin
                r_rd <= AW'((32'(r_rd) + 1) % QUEUE_DEPTH);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op[r_wr]  <= w_op;
            r_per[r_wr] <= w_period;
        end
    end

endmodule

`default_nettype wire

[rtl/hlcm_div.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend by a
// period-wide divisor; runs a given number of steps. Uses hlcm_pkg.
`default_nettype none

module hlcm_div #(
    parameter int PB = hlcm_pkg::PERIOD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hlcm_pkg::HP_W-1:0]   i_dividend,
    input  logic [PB-1:0]               i_divisor,
    input  logic [hlcm_pkg::CNT_W-1:0]  i_iters,
    output logic                        o_done,
    output logic [hlcm_pkg::HP_W-1:0]   o_quot,
    output logic [PB-1:0]               o_rem
);
    import hlcm_pkg::*;

    logic [HP_W-1:0]  r_sh;
    logic [PB-1:0]    r_rem;
    logic [PB-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [PB:0]      w_trial;
    logic [PB:0]      w_diff;
    logic             w_ge;
    logic [PB-1:0]    n_rem;
    logic [HP_W-1:0]  n_sh;

    assign w_trial = {r_rem, r_sh[HP_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign n_rem   = w_ge ? w_diff[PB-1:0] : w_trial[PB-1:0];
    assign n_sh    = {r_sh[HP_W-2:0], w_ge};

    assign o_done = r_done;
    assign o_quot = r_sh;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_sh  <= n_sh;
            r_rem <= n_rem;
        end
    end

endmodule

`default_nettype wire

[rtl/hlcm_gcd.sv]
// Binary gcd of two nonzero period-wide values, one step per cycle.
// Uses hlcm_pkg for the default period width.
`default_nettype none

module hlcm_gcd #(
    parameter int PB = hlcm_pkg::PERIOD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PB-1:0] i_a,
    input  logic [PB-1:0] i_b,
    output logic          o_done,
    output logic [PB-1:0] o_gcd
);
    localparam int KW = $clog2(PB);

    logic [PB-1:0] r_a;
    logic [PB-1:0] r_b;
    logic [KW-1:0] r_k;
    logic          r_busy;
    logic          r_done;

    logic [PB-1:0] n_a;
    logic [PB-1:0] n_b;
    logic [KW-1:0] n_k;
    logic          w_eq;

    assign w_eq   = (r_a == r_b);
    assign o_done = r_done;
    assign o_gcd  = r_a << r_k;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        priority if (w_eq) begin
            n_a = r_a;
        end else if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + KW'(1);
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a > r_b) begin
            n_a = (r_a - r_b) >> 1;
        end else begin
            n_b = (r_b - r_a) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_eq) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_k <= '0;
        end else if (r_busy) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end
    end

endmodule

`default_nettype wire

[rtl/hlcm_back.sv]
// Back end: holds the running multiple, sequences remainder, gcd, division
// and a split multiply, and drives the result register.
// Uses hlcm_pkg, hlcm_result_if, hlcm_div and hlcm_gcd.
`default_nettype none

module hlcm_back #(
    parameter int PB = hlcm_pkg::PERIOD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  hlcm_pkg::t_op    i_cmd_op,
    input  logic [PB-1:0]    i_cmd_period,
    hlcm_result_if.source    o_result,
    output logic             o_busy
);
    import hlcm_pkg::*;

    localparam int PROD_W = HALF_W + PB;

    t_state             r_state;
    t_state             n_state;
    logic [HP_W-1:0]    r_m;
    logic [HP_W-1:0]    n_m;
    logic               r_ov;
    logic               n_ov;
    logic [PB-1:0]      r_p;
    logic [PB-1:0]      r_d;
    logic [PROD_W-1:0]  r_plo;
    logic [PROD_W-1:0]  r_phi;
    logic               r_out_valid;
    logic [HP_W-1:0]    r_out_hp;
    logic               r_out_ov;

    logic               w_take;
    logic               w_slot;
    logic               w_div_start;
    logic [HP_W-1:0]    w_div_dividend;
    logic [PB-1:0]      w_div_divisor;
    logic [CNT_W-1:0]   w_div_iters;
    logic               w_div_done;
    logic [HP_W-1:0]    w_div_quot;
    logic [PB-1:0]      w_div_rem;
    logic               w_gcd_start;
    logic               w_gcd_done;
    logic [PB-1:0]      w_gcd;
    logic [HALF_W-1:0]  w_mul_a;
    logic [PROD_W-1:0]  w_prod;
    logic [HALF_W:0]    w_mid;
    logic               w_mul_ovf;
    logic               w_needs_div;

    hlcm_div #(.PB(PB)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .i_iters    (w_div_iters),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    hlcm_gcd #(.PB(PB)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (r_p),
        .i_b     (w_div_rem),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    assign w_take      = i_cmd_valid && (r_state == S_IDLE);
    assign w_slot      = !r_out_valid || o_result.ready;
    assign w_needs_div = (i_cmd_op == OP_COMBINE) && !r_ov && (r_m != '0);

    assign w_mul_a = (r_state == S_MUL_LO) ? r_m[HALF_W-1:0] : r_m[HP_W-1:HALF_W];
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(r_d);
    assign w_mid   = {1'b0, r_phi[HALF_W-1:0]} + (HALF_W + 1)'(r_plo[PROD_W-1:HALF_W]);
    assign w_mul_ovf = (r_phi[PROD_W-1:HALF_W] != '0) || w_mid[HALF_W];

    assign o_cmd_ready          = (r_state == S_IDLE);
    assign o_busy               = (r_state != S_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.hyperperiod = r_out_hp;
    assign o_result.overflow    = r_out_ov;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = w_needs_div ? S_MOD : S_WRITE;
                end
            end
            S_MOD: begin
                if (w_div_done) begin
                    n_state = (w_div_rem == '0) ? S_WRITE : S_GCD;
                end
            end
            S_GCD: begin
                if (w_gcd_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SUM;
            S_SUM:    n_state = S_WRITE;
            S_WRITE: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_m            = r_m;
        n_ov           = r_ov;
        w_div_start    = 1'b0;
        w_div_dividend = r_m;
        w_div_divisor  = i_cmd_period;
        w_div_iters    = CNT_W'(HP_W);
        w_gcd_start    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    unique case (i_cmd_op)
                        OP_START: begin
                            n_m  = HP_W'(i_cmd_period);
                            n_ov = 1'b0;
                        end
                        OP_COMBINE: begin
                            if (!r_ov && (r_m == '0)) begin
                                n_m = HP_W'(i_cmd_period);
                            end
                            w_div_start = w_needs_div;
                        end
                        OP_HOLD: n_m = r_m;
                        default: n_m = r_m;
                    endcase
                end
            end
            S_MOD: begin
                w_gcd_start = w_div_done && (w_div_rem != '0);
            end
            S_GCD: begin
                w_div_start    = w_gcd_done;
                w_div_dividend = {r_p, {(HP_W - PB){1'b0}}};
                w_div_divisor  = w_gcd;
                w_div_iters    = CNT_W'(PB);
            end
            S_SUM: begin
                if (w_mul_ovf) begin
                    n_m  = '1;
                    n_ov = 1'b1;
                end else begin
                    n_m = {w_mid[HALF_W-1:0], r_plo[HALF_W-1:0]};
                end
            end
            S_DIV, S_MUL_LO, S_MUL_HI, S_WRITE: begin
                n_m = r_m;
            end
            default: n_m = r_m;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= '0;
            r_ov        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
            r_ov    <= n_ov;
            if ((r_state == S_WRITE) && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_p <= i_cmd_period;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_d <= w_div_quot[PB-1:0];
        end
        if (r_state == S_MUL_LO) begin
            r_plo <= w_prod;
        end
        if (r_state == S_MUL_HI) begin
            r_phi <= w_prod;
        end
        if ((r_state == S_WRITE) && w_slot) begin
            r_out_hp <= r_m;
            r_out_ov <= r_ov;
        end
    end

endmodule

`default_nettype wire

[rtl/hyperperiod_lcm_accumulator_core.sv]
// Hyperperiod accumulator top level: front classifier, command queue and
// back-end lcm sequencer. Uses hlcm_pkg, hlcm_if, hlcm_front and hlcm_back.
//
// Usage: task periods enter on i_task (period, first); each beat yields one
// beat on o_result with the least common multiple of the periods of the
// current set and a sticky overflow flag (value all ones on overflow).
// first = 1 starts a new set with that period; a zero period with first = 0
// reports the state unchanged; an empty set reports 0.
// Sequence: a set start, a held beat, the first period of a set or any beat
// after overflow goes straight to the result; a period that divides the
// multiple needs only the remainder steps. Other combining beats take
// 64 remainder steps, up to 2*PERIOD_BITS+1 binary gcd steps, PERIOD_BITS
// division steps, then a low and a high partial product and a sum; the
// one-bit-per-cycle divider is shared by the remainder and the division.
// One item is worked on at a time.
// Two beats queue in front of the back end, and the result register holds
// one finished beat, so input is taken while a result waits.
// A stalled receiver holds the result; the back end then waits for the slot.
// Reset (synchronous, active low) empties the queue, clears the running
// multiple and overflow flag, and drops any pending result.
`default_nettype none

module hyperperiod_lcm_accumulator_core #(
    parameter int PERIOD_BITS = hlcm_pkg::PERIOD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hlcm_task_if.sink     i_task,
    hlcm_result_if.source o_result
);
    import hlcm_pkg::*;

    logic                   w_cmd_valid;
    logic                   w_cmd_ready;
    t_op                    w_cmd_op;
    logic [PERIOD_BITS-1:0] w_cmd_period;
    logic                   w_back_busy;

    hlcm_front #(.PB(PERIOD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task       (i_task),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd_op     (w_cmd_op),
        .o_cmd_period (w_cmd_period)
    );

    hlcm_back #(.PB(PERIOD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd_op     (w_cmd_op),
        .i_cmd_period (w_cmd_period),
        .o_result     (o_result),
        .o_busy       (w_back_busy)
    );

`ifndef NO_ASSERTIONS
    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.overflow |-> (o_result.hyperperiod == '1))
        else $error("overflow result not saturated");

    a_result_from_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_back_busy))
        else $error("result appeared without back-end work");

    a_pop_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_valid && w_cmd_ready |=> w_back_busy)
        else $error("command popped but back end stayed idle");
`endif

endmodule

`default_nettype wire
